// ===== hdl/point_to_pixel_projection_assert.svh =====
// ----------------------------------------------------------------------------
// Point-to-pixel projection assertion macros
// Shared property wrappers for the checks in the projection block.
// ----------------------------------------------------------------------------
`ifndef POINT_TO_PIXEL_PROJECTION_ASSERT_SVH
`define POINT_TO_PIXEL_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PTP_ASSERT_IMP(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("point_to_pixel_projection: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PTP_ASSERT_NXT(name, ck, rstn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("point_to_pixel_projection: next-cycle check failed");

`endif

// ===== hdl/ptp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-pixel projection package
// Field widths, register codes, reset values and width helpers.
// ----------------------------------------------------------------------------
package ptp_pkg;

	// Default parameter values.
	localparam int POINT_BITS_DEF = 16;
	localparam int PIXEL_BITS_DEF = 12;

	// Fixed field widths of the register layout.
	localparam int ROT_W          = 16;
	localparam int ROT_FRAC_SHIFT = 14;
	localparam int CAM_W          = 20;
	localparam int XF_REG_W       = 64;
	localparam int CAM_REG_W      = 60;
	localparam int ROI_REG_W      = 24;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_IDX_W      = 4;

	// Register reset values.
	localparam logic [XF_REG_W-1:0]  XF_ROW0_RST  = 64'd16384;
	localparam logic [XF_REG_W-1:0]  XF_ROW1_RST  = 64'd1073741824;
	localparam logic [XF_REG_W-1:0]  XF_ROW2_RST  = 64'd70368744177664;
	localparam logic [CAM_REG_W-1:0] CAM_ROW0_RST = 60'd64;
	localparam logic [CAM_REG_W-1:0] CAM_ROW1_RST = 60'd67108864;
	localparam logic [CAM_REG_W-1:0] CAM_ROW2_RST = 60'd70368744177664;
	localparam logic [ROI_REG_W-1:0] ROI_ORG_RST  = 24'd0;
	localparam logic [ROI_REG_W-1:0] ROI_SIZE_RST = 24'd4425600;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_XF_ROW0  = 4'd0,
		CFG_XF_ROW1  = 4'd1,
		CFG_XF_ROW2  = 4'd2,
		CFG_CAM_ROW0 = 4'd3,
		CFG_CAM_ROW1 = 4'd4,
		CFG_CAM_ROW2 = 4'd5,
		CFG_ROI_ORG  = 4'd6,
		CFG_ROI_SIZE = 4'd7
	} cfg_reg_t;

	// Width of a camera-frame coordinate in Q.14: three rotation products
	// plus the scaled translation.
	function automatic int c_width(input int pb);
		int pw;
		int tw;
		pw = ROT_W + pb;
		tw = ROT_W + ROT_FRAC_SHIFT;
		return ((pw > tw) ? pw : tw) + 2;
	endfunction

	// Width of a homogeneous coordinate in Q.20.
	function automatic int h_width(input int pb);
		return CAM_W + c_width(pb) + 2;
	endfunction

endpackage

// ===== hdl/point_to_pixel_projection.sv =====
`timescale 1ns / 1ps
// Projects one 3-D point per clock, when not stalled, onto the image plane:
// a rigid transform, a camera matrix, then floor division of column and row
// by the depth. A new point is taken every cycle unless the skid entry is
// occupied; the quotient pipeline resolves one pixel bit per stage. Non-finite
// points, zero depth and pixels outside the region of interest give no result.
// A two-entry output (register plus skid) decouples the stall from the input
// side. Registers are to be written by the user only while the block is idle;
// the block itself does not enforce this. cfg_ready is always high.
// ----------------------------------------------------------------------------
// Point-to-pixel projection top level
// Configuration registers, point delay line, region test and output skid.
// ----------------------------------------------------------------------------
`include "point_to_pixel_projection_assert.svh"

module point_to_pixel_projection #(
	parameter int PIXEL_BITS = ptp_pkg::PIXEL_BITS_DEF,
	parameter int POINT_BITS = ptp_pkg::POINT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ptp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// Point input channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [POINT_BITS-1:0]      point_x,
	input  logic signed [POINT_BITS-1:0]      point_y,
	input  logic signed [POINT_BITS-1:0]      point_z,
	input  logic                              point_finite,
	// Pixel output channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [PIXEL_BITS-1:0]             pixel_col,
	output logic [PIXEL_BITS-1:0]             pixel_row,
	output logic signed [POINT_BITS-1:0]      out_x,
	output logic signed [POINT_BITS-1:0]      out_y,
	output logic signed [POINT_BITS-1:0]      out_z
);

	localparam int CW    = ptp_pkg::c_width(POINT_BITS);
	localparam int HW    = ptp_pkg::h_width(POINT_BITS);
	localparam int DEPTH = 2 + 3 + PIXEL_BITS + 2;
	localparam int RW    = (2 * PIXEL_BITS > ptp_pkg::ROI_REG_W) ?
		2 * PIXEL_BITS : ptp_pkg::ROI_REG_W;

	// Configuration registers.
	logic [ptp_pkg::XF_REG_W-1:0]  xf_q   [3];
	logic [ptp_pkg::CAM_REG_W-1:0] cam_q  [3];
	logic [ptp_pkg::ROI_REG_W-1:0] roi_org_q;
	logic [ptp_pkg::ROI_REG_W-1:0] roi_size_q;

	logic signed [ptp_pkg::ROT_W-1:0] rot   [3][3];
	logic signed [ptp_pkg::ROT_W-1:0] trans [3];
	logic signed [ptp_pkg::CAM_W-1:0] cam   [3][3];
	logic signed [POINT_BITS-1:0]     pnt   [3];
	logic signed [CW-1:0]             c     [3];
	logic signed [HW-1:0]             h     [3];

	logic                  en;
	logic [PIXEL_BITS-1:0] col;
	logic [PIXEL_BITS-1:0] row;
	logic                  bad_col;
	logic                  bad_row;

	// Delay line that carries validity and the original point.
	logic                         vld_s [DEPTH];
	logic signed [POINT_BITS-1:0] px_s  [DEPTH];
	logic signed [POINT_BITS-1:0] py_s  [DEPTH];
	logic signed [POINT_BITS-1:0] pz_s  [DEPTH];

	// Region bounds.
	logic [RW-1:0]         org_ext;
	logic [RW-1:0]         size_ext;
	logic [PIXEL_BITS-1:0] roi_x0;
	logic [PIXEL_BITS-1:0] roi_y0;
	logic [PIXEL_BITS:0]   roi_x1;
	logic [PIXEL_BITS:0]   roi_y1;
	logic                  fin_valid;
	logic                  out_in_roi;

	// Output register and skid entry.
	logic                         out_valid_q;
	logic [PIXEL_BITS-1:0]        pixel_col_q;
	logic [PIXEL_BITS-1:0]        pixel_row_q;
	logic signed [POINT_BITS-1:0] out_x_q;
	logic signed [POINT_BITS-1:0] out_y_q;
	logic signed [POINT_BITS-1:0] out_z_q;
	logic                         skid_vld_q;
	logic [PIXEL_BITS-1:0]        skid_col_q;
	logic [PIXEL_BITS-1:0]        skid_row_q;
	logic signed [POINT_BITS-1:0] skid_x_q;
	logic signed [POINT_BITS-1:0] skid_y_q;
	logic signed [POINT_BITS-1:0] skid_z_q;

	// Register writes; an index past the list is dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xf_q[0]    <= ptp_pkg::XF_ROW0_RST;
			xf_q[1]    <= ptp_pkg::XF_ROW1_RST;
			xf_q[2]    <= ptp_pkg::XF_ROW2_RST;
			cam_q[0]   <= ptp_pkg::CAM_ROW0_RST;
			cam_q[1]   <= ptp_pkg::CAM_ROW1_RST;
			cam_q[2]   <= ptp_pkg::CAM_ROW2_RST;
			roi_org_q  <= ptp_pkg::ROI_ORG_RST;
			roi_size_q <= ptp_pkg::ROI_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ptp_pkg::cfg_reg_t'(cfg_index))
				ptp_pkg::CFG_XF_ROW0:  xf_q[0]    <= cfg_data;
				ptp_pkg::CFG_XF_ROW1:  xf_q[1]    <= cfg_data;
				ptp_pkg::CFG_XF_ROW2:  xf_q[2]    <= cfg_data;
				ptp_pkg::CFG_CAM_ROW0: cam_q[0]   <= cfg_data[ptp_pkg::CAM_REG_W-1:0];
				ptp_pkg::CFG_CAM_ROW1: cam_q[1]   <= cfg_data[ptp_pkg::CAM_REG_W-1:0];
				ptp_pkg::CFG_CAM_ROW2: cam_q[2]   <= cfg_data[ptp_pkg::CAM_REG_W-1:0];
				ptp_pkg::CFG_ROI_ORG:  roi_org_q  <= cfg_data[ptp_pkg::ROI_REG_W-1:0];
				ptp_pkg::CFG_ROI_SIZE: roi_size_q <= cfg_data[ptp_pkg::ROI_REG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Unpack the matrix entries.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				rot[i][j] = xf_q[i][ptp_pkg::ROT_W*j +: ptp_pkg::ROT_W];
				cam[i][j] = cam_q[i][ptp_pkg::CAM_W*j +: ptp_pkg::CAM_W];
			end
			trans[i] = xf_q[i][3*ptp_pkg::ROT_W +: ptp_pkg::ROT_W];
		end
		pnt[0] = point_x;
		pnt[1] = point_y;
		pnt[2] = point_z;
	end

	// The whole pipeline advances unless the skid entry is occupied.
	assign en       = !skid_vld_q;
	assign in_stall = skid_vld_q;

	ptp_xform #(
		.POINT_BITS(POINT_BITS)
	) u_xform (
		.clk  (clk),
		.en   (en),
		.p    (pnt),
		.rot  (rot),
		.trans(trans),
		.c    (c)
	);

	ptp_proj #(
		.POINT_BITS(POINT_BITS)
	) u_proj (
		.clk(clk),
		.en (en),
		.c  (c),
		.cam(cam),
		.h  (h)
	);

	ptp_fdiv #(
		.AW(HW),
		.QW(PIXEL_BITS)
	) u_div_col (
		.clk(clk),
		.en (en),
		.num(h[0]),
		.den(h[2]),
		.q  (col),
		.bad(bad_col)
	);

	ptp_fdiv #(
		.AW(HW),
		.QW(PIXEL_BITS)
	) u_div_row (
		.clk(clk),
		.en (en),
		.num(h[1]),
		.den(h[2]),
		.q  (row),
		.bad(bad_row)
	);

	// Validity line; non-finite points enter as bubbles.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= in_valid && point_finite;
			for (int k = 1; k < DEPTH; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// Original point travels beside the arithmetic.
	always_ff @(posedge clk) begin
		if (en) begin
			px_s[0] <= point_x;
			py_s[0] <= point_y;
			pz_s[0] <= point_z;
			for (int k = 1; k < DEPTH; k++) begin
				px_s[k] <= px_s[k-1];
				py_s[k] <= py_s[k-1];
				pz_s[k] <= pz_s[k-1];
			end
		end
	end

	// Region bounds; the end is one bit wider, so clipping is implicit.
	always_comb begin
		org_ext  = RW'(roi_org_q);
		size_ext = RW'(roi_size_q);
		roi_x0   = org_ext[PIXEL_BITS-1:0];
		roi_y0   = org_ext[2*PIXEL_BITS-1:PIXEL_BITS];
		roi_x1   = (PIXEL_BITS+1)'(roi_x0) + (PIXEL_BITS+1)'(size_ext[PIXEL_BITS-1:0]);
		roi_y1   = (PIXEL_BITS+1)'(roi_y0)
			+ (PIXEL_BITS+1)'(size_ext[2*PIXEL_BITS-1:PIXEL_BITS]);
	end

	assign fin_valid = vld_s[DEPTH-1] && !bad_col && !bad_row
		&& (col >= roi_x0) && ((PIXEL_BITS+1)'(col) < roi_x1)
		&& (row >= roi_y0) && ((PIXEL_BITS+1)'(row) < roi_y1);

	// Output control: register plus one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (skid_vld_q) begin
			if (!out_stall) begin
				skid_vld_q <= 1'b0;
			end
		end else if (out_valid_q && out_stall) begin
			skid_vld_q <= fin_valid;
		end else begin
			out_valid_q <= fin_valid;
		end
	end

	// Output and skid payload.
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!out_stall) begin
				pixel_col_q <= skid_col_q;
				pixel_row_q <= skid_row_q;
				out_x_q     <= skid_x_q;
				out_y_q     <= skid_y_q;
				out_z_q     <= skid_z_q;
			end
		end else if (out_valid_q && out_stall) begin
			skid_col_q <= col;
			skid_row_q <= row;
			skid_x_q   <= px_s[DEPTH-1];
			skid_y_q   <= py_s[DEPTH-1];
			skid_z_q   <= pz_s[DEPTH-1];
		end else begin
			pixel_col_q <= col;
			pixel_row_q <= row;
			out_x_q     <= px_s[DEPTH-1];
			out_y_q     <= py_s[DEPTH-1];
			out_z_q     <= pz_s[DEPTH-1];
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_col = pixel_col_q;
	assign pixel_row = pixel_row_q;
	assign out_x     = out_x_q;
	assign out_y     = out_y_q;
	assign out_z     = out_z_q;

	// Region test on the held output beat.
	assign out_in_roi = (pixel_col_q >= roi_x0) && ((PIXEL_BITS+1)'(pixel_col_q) < roi_x1)
		&& (pixel_row_q >= roi_y0) && ((PIXEL_BITS+1)'(pixel_row_q) < roi_y1);

	// The skid entry only fills behind a held output beat.
	`PTP_ASSERT_IMP(a_skid_behind_out, clk, arst_n, skid_vld_q, out_valid_q)
	// A held skid entry stays put while the output is stalled.
	`PTP_ASSERT_NXT(a_skid_holds, clk, arst_n, skid_vld_q && out_stall, skid_vld_q && $stable(skid_x_q))
	// A non-finite point never enters the pipeline as valid.
	`PTP_ASSERT_NXT(a_nonfinite_dropped, clk, arst_n, in_valid && !in_stall && !point_finite, !vld_s[0])
	// Every delivered pixel lies inside the region.
	`PTP_ASSERT_IMP(a_pixel_in_roi, clk, arst_n, out_valid_q, out_in_roi)

endmodule

// ===== hdl/ptp_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rigid transform stage
// Rotates the point and adds the translation, giving the camera-frame
// point in Q.14 after two register stages.
// ----------------------------------------------------------------------------
module ptp_xform #(
	parameter int POINT_BITS = ptp_pkg::POINT_BITS_DEF,
	localparam int CW = ptp_pkg::c_width(POINT_BITS)
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic signed [POINT_BITS-1:0]    p     [3],
	input  logic signed [ptp_pkg::ROT_W-1:0] rot  [3][3],
	input  logic signed [ptp_pkg::ROT_W-1:0] trans [3],
	output logic signed [CW-1:0]            c     [3]
);

	localparam int PW = ptp_pkg::ROT_W + POINT_BITS;

	logic signed [PW-1:0] prod_s1 [3][3];
	logic signed [CW-1:0] c_s2    [3];

	// Stage 1: the nine rotation products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s1[i][j] <= PW'(rot[i][j]) * PW'(p[j]);
				end
			end
		end
	end

	// Stage 2: row sums plus the translation scaled to Q.14.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				c_s2[i] <= CW'(prod_s1[i][0]) + CW'(prod_s1[i][1]) + CW'(prod_s1[i][2])
					+ (CW'(trans[i]) <<< ptp_pkg::ROT_FRAC_SHIFT);
			end
		end
	end

	assign c = c_s2;

endmodule

// ===== hdl/ptp_proj.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera matrix stage
// Multiplies the camera-frame point by the camera matrix. Each product is
// split into a low and a high partial product, then recombined and summed
// over three register stages.
// ----------------------------------------------------------------------------
module ptp_proj #(
	parameter int POINT_BITS = ptp_pkg::POINT_BITS_DEF,
	localparam int CW = ptp_pkg::c_width(POINT_BITS),
	localparam int HW = ptp_pkg::h_width(POINT_BITS)
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [CW-1:0]             c   [3],
	input  logic signed [ptp_pkg::CAM_W-1:0] cam [3][3],
	output logic signed [HW-1:0]             h   [3]
);

	localparam int LO_W  = CW / 2;
	localparam int HI_W  = CW - LO_W;
	localparam int PLO_W = ptp_pkg::CAM_W + LO_W + 1;
	localparam int PHI_W = ptp_pkg::CAM_W + HI_W;

	logic signed [LO_W:0]    c_lo   [3];
	logic signed [HI_W-1:0]  c_hi   [3];
	logic signed [PLO_W-1:0] plo_s3 [3][3];
	logic signed [PHI_W-1:0] phi_s3 [3][3];
	logic signed [HW-1:0]    t_s4   [3][3];
	logic signed [HW-1:0]    h_s5   [3];

	// Split each coordinate into an unsigned low half and a signed high half.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			c_lo[j] = signed'({1'b0, c[j][LO_W-1:0]});
			c_hi[j] = signed'(c[j][CW-1:LO_W]);
		end
	end

	// Stage 3: partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					plo_s3[i][j] <= PLO_W'(cam[i][j]) * PLO_W'(c_lo[j]);
					phi_s3[i][j] <= PHI_W'(cam[i][j]) * PHI_W'(c_hi[j]);
				end
			end
		end
	end

	// Stage 4: recombine the halves of each product.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					t_s4[i][j] <= (HW'(phi_s3[i][j]) <<< LO_W) + HW'(plo_s3[i][j]);
				end
			end
		end
	end

	// Stage 5: row sums.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				h_s5[i] <= t_s4[i][0] + t_s4[i][1] + t_s4[i][2];
			end
		end
	end

	assign h = h_s5;

endmodule

// ===== hdl/ptp_fdiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined floor divider
// Computes floor(num / den) when it lies in [0, 2^QW), one quotient bit
// per stage. Any other quotient, or a zero divisor, raises bad.
// ----------------------------------------------------------------------------
module ptp_fdiv #(
	parameter int AW = 64,
	parameter int QW = ptp_pkg::PIXEL_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [AW-1:0] num,
	input  logic signed [AW-1:0] den,
	output logic [QW-1:0]        q,
	output logic                 bad
);

	localparam int XW = AW + QW;

	logic                 den_neg;
	logic [AW-1:0]        b_mag;
	logic signed [AW:0]   a_norm;
	logic signed [AW:0]   a_s1;
	logic [AW-1:0]        b_s1;
	logic                 zero_s1;
	logic                 ovf;
	logic [AW-1:0]        r_st   [QW+1];
	logic [AW-1:0]        b_st   [QW+1];
	logic [QW-1:0]        q_st   [QW+1];
	logic                 bad_st [QW+1];

	// Make the divisor positive; floor(a/b) equals floor(-a/-b).
	always_comb begin
		den_neg = den[AW-1];
		b_mag   = den_neg ? AW'(-den) : AW'(den);
		a_norm  = den_neg ? -((AW+1)'(num)) : (AW+1)'(num);
	end

	// Stage 1: sign normalization.
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a_norm;
			b_s1    <= b_mag;
			zero_s1 <= (den == '0);
		end
	end

	// A quotient of 2^QW or more, or a negative one, lies outside any region.
	assign ovf = (XW'(a_s1[AW-1:0]) >= (XW'(b_s1) << QW));

	// Stage 2: range check and remainder setup.
	always_ff @(posedge clk) begin
		if (en) begin
			r_st[0]   <= a_s1[AW-1:0];
			b_st[0]   <= b_s1;
			q_st[0]   <= '0;
			bad_st[0] <= zero_s1 || a_s1[AW] || ovf;
		end
	end

	// Restoring division, most significant quotient bit first.
	for (genvar g = 0; g < QW; g++) begin : g_bit
		localparam int BIT = QW - 1 - g;

		logic [XW-1:0] shd;
		logic          fit;

		always_comb begin
			shd = XW'(b_st[g]) << BIT;
			fit = (XW'(r_st[g]) >= shd);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_st[g+1]   <= fit ? AW'(XW'(r_st[g]) - shd) : r_st[g];
				b_st[g+1]   <= b_st[g];
				q_st[g+1]   <= q_st[g] | (QW'(fit) << BIT);
				bad_st[g+1] <= bad_st[g];
			end
		end
	end

	assign q   = q_st[QW];
	assign bad = bad_st[QW];

endmodule

// ===== sim/point_to_pixel_projection_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point-to-pixel projection testbench
// Streams points through the projection block across several register
// settings and checks each pixel beat against an in-bench predictor.
// ----------------------------------------------------------------------------
module point_to_pixel_projection_test;

	localparam int PB = 12;
	localparam int QB = 16;
	localparam int SETTLE = PB + 12;
	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic signed [QB-1:0] x;
		logic signed [QB-1:0] y;
		logic signed [QB-1:0] z;
		logic                 fin;
	} point_t;

	typedef struct packed {
		logic [PB-1:0]        col;
		logic [PB-1:0]        row;
		logic signed [QB-1:0] x;
		logic signed [QB-1:0] y;
		logic signed [QB-1:0] z;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [ptp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ptp_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [QB-1:0] point_x = '0;
	logic signed [QB-1:0] point_y = '0;
	logic signed [QB-1:0] point_z = '0;
	logic point_finite = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PB-1:0] pixel_col;
	logic [PB-1:0] pixel_row;
	logic signed [QB-1:0] out_x;
	logic signed [QB-1:0] out_y;
	logic signed [QB-1:0] out_z;

	// Shadow copy of the configuration registers.
	logic [63:0] xf_row [3];
	logic [59:0] cam_row [3];
	logic [23:0] roi_org;
	logic [23:0] roi_sz;

	point_t pending_points [$];
	pixel_t expected_pixels [$];
	int errors = 0;
	int cycles = 0;
	bit calm = 1'b0;
	bit in_taken = 1'b0;
	int in_gap = 0;
	int out_gap = 0;

	point_to_pixel_projection #(.PIXEL_BITS(PB), .POINT_BITS(QB)) DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.point_finite(point_finite),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_x(out_x), .out_y(out_y), .out_z(out_z)
	);

	// Clock and a single reset pulse.
	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Appends a point to the tail of the send queue.
	function automatic void enqueue_point(input point_t p);
		pending_points.insert(pending_points.size(), p);
	endfunction

	// Floor division that rounds toward minus infinity.
	function automatic longint floor_quot(longint a, longint b);
		longint q;
		longint r;
		q = a / b;
		r = a % b;
		if (r != 0 && ((r < 0) != (b < 0))) q = q - 1;
		return q;
	endfunction

	// Projects a point with the current registers; returns 1 when a pixel
	// beat is due.
	function automatic bit project_point(input point_t p, output pixel_t px);
		longint pt [3];
		longint cf [3];
		longint hv [3];
		longint e;
		longint col, row, ox, oy, ex, ey;
		px = '0;
		if (!p.fin) return 1'b0;
		pt[0] = p.x;
		pt[1] = p.y;
		pt[2] = p.z;
		for (int i = 0; i < 3; i++) begin
			e = $signed(xf_row[i][63:48]);
			cf[i] = e * 16384;
			for (int j = 0; j < 3; j++) begin
				e = $signed(xf_row[i][16*j +: 16]);
				cf[i] += e * pt[j];
			end
		end
		for (int i = 0; i < 3; i++) begin
			hv[i] = 0;
			for (int j = 0; j < 3; j++) begin
				e = $signed(cam_row[i][20*j +: 20]);
				hv[i] += e * cf[j];
			end
		end
		if (hv[2] == 0) return 1'b0;
		col = floor_quot(hv[0], hv[2]);
		row = floor_quot(hv[1], hv[2]);
		ox = roi_org[PB-1:0];
		oy = roi_org[2*PB-1:PB];
		ex = ox + roi_sz[PB-1:0];
		ey = oy + roi_sz[2*PB-1:PB];
		if (ex > (1 << PB)) ex = 1 << PB;
		if (ey > (1 << PB)) ey = 1 << PB;
		if (col < ox || col >= ex || row < oy || row >= ey) return 1'b0;
		px.col = col[PB-1:0];
		px.row = row[PB-1:0];
		px.x = p.x;
		px.y = p.y;
		px.z = p.z;
		return 1'b1;
	endfunction

	// Point driver: new beats and idle bursts change at the falling edge.
	always @(negedge clk) begin
		bit load;
		point_t p;
		load = !in_valid || in_taken;
		if (load) begin
			if (in_gap > 0) begin
				in_gap <= in_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_points.size() > 0) begin
				p = pending_points.pop_front();
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
				point_finite <= p.fin;
				in_valid <= 1'b1;
				if (!calm && $urandom_range(0, 15) == 0) in_gap <= $urandom_range(1, 14);
			end else begin
				in_valid <= 1'b0;
			end
		end
		// Receiver stall bursts.
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			out_gap <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: predicts on accepted points and checks pixel beats.
	always @(posedge clk) begin
		pixel_t px;
		pixel_t want;
		point_t p;
		cycles <= cycles + 1;
		in_taken <= in_valid && !in_stall && arst_n;
		if (arst_n && in_valid && !in_stall) begin
			p = {point_x, point_y, point_z, point_finite};
			if (project_point(p, px)) expected_pixels.insert(expected_pixels.size(), px);
		end
		if (arst_n && out_valid && !out_stall) begin
			px = {pixel_col, pixel_row, out_x, out_y, out_z};
			if (expected_pixels.size() == 0) begin
				errors = errors + 1;
				$display("%0t: unexpected beat, expected none, actual %h", $realtime, px);
			end else begin
				want = expected_pixels.pop_front();
				if (px.col !== want.col) begin
					errors = errors + 1;
					$display("%0t: pixel_col expected %0d actual %0d",
						$realtime, want.col, px.col);
				end
				if (px.row !== want.row) begin
					errors = errors + 1;
					$display("%0t: pixel_row expected %0d actual %0d",
						$realtime, want.row, px.row);
				end
				if (px.x !== want.x || px.y !== want.y || px.z !== want.z) begin
					errors = errors + 1;
					$display("%0t: point expected %0d,%0d,%0d actual %0d,%0d,%0d",
						$realtime, want.x, want.y, want.z, px.x, px.y, px.z);
				end
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("point_to_pixel_projection verification failed");
			$finish;
		end
	end

	// One register write beat; the shadow follows the same masking.
	task automatic write_reg(input logic [ptp_pkg::CFG_IDX_W-1:0] idx,
		input logic [63:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx) inside
			ptp_pkg::CFG_XF_ROW0, ptp_pkg::CFG_XF_ROW1, ptp_pkg::CFG_XF_ROW2:
				xf_row[idx] = val;
			ptp_pkg::CFG_CAM_ROW0, ptp_pkg::CFG_CAM_ROW1, ptp_pkg::CFG_CAM_ROW2:
				cam_row[idx - ptp_pkg::CFG_CAM_ROW0] = val[59:0];
			ptp_pkg::CFG_ROI_ORG: roi_org = val[23:0];
			ptp_pkg::CFG_ROI_SIZE: roi_sz = val[23:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Holds the sender until the pipeline is empty.
	task automatic drain();
		while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic load_identity();
		write_reg(ptp_pkg::CFG_XF_ROW0, ptp_pkg::XF_ROW0_RST);
		write_reg(ptp_pkg::CFG_XF_ROW1, ptp_pkg::XF_ROW1_RST);
		write_reg(ptp_pkg::CFG_XF_ROW2, ptp_pkg::XF_ROW2_RST);
		write_reg(ptp_pkg::CFG_CAM_ROW0, 64'hF000_0000_0000_0000 | ptp_pkg::CAM_ROW0_RST);
		write_reg(ptp_pkg::CFG_CAM_ROW1, 64'(ptp_pkg::CAM_ROW1_RST));
		write_reg(ptp_pkg::CFG_CAM_ROW2, 64'(ptp_pkg::CAM_ROW2_RST));
	endtask

	function automatic point_t any_point();
		point_t p;
		p.x = QB'($urandom);
		p.y = QB'($urandom);
		p.z = QB'($urandom);
		p.fin = $urandom_range(0, 9) != 0;
		return p;
	endfunction

	// Coordinate that lands on a chosen pixel for an identity projection.
	function automatic logic signed [QB-1:0] aim(int pix, int depth);
		int v;
		if (depth > 0) v = pix * depth + $urandom_range(0, depth - 1);
		else v = pix * depth - $urandom_range(0, -depth - 1);
		return QB'(v);
	endfunction

	// When aimed, mostly points aimed around the region, some plain noise; otherwise plain noise.
	task automatic queue_points(input int n, input bit aimed);
		point_t p;
		int ox, oy, w, h, d;
		for (int k = 0; k < n; k++) begin
			p = any_point();
			if (aimed && $urandom_range(0, 9) < 8) begin
				ox = roi_org[PB-1:0];
				oy = roi_org[2*PB-1:PB];
				w = roi_sz[PB-1:0];
				h = roi_sz[2*PB-1:PB];
				d = $urandom_range(1, 7);
				if ($urandom_range(0, 1)) d = -d;
				p.z = QB'(d);
				p.x = aim(ox - 2 + $urandom_range(0, w + 3), d);
				p.y = aim(oy - 2 + $urandom_range(0, h + 3), d);
			end
			enqueue_point(p);
		end
	endtask

	initial begin
		point_t p;
		xf_row[0] = ptp_pkg::XF_ROW0_RST;
		xf_row[1] = ptp_pkg::XF_ROW1_RST;
		xf_row[2] = ptp_pkg::XF_ROW2_RST;
		cam_row[0] = ptp_pkg::CAM_ROW0_RST;
		cam_row[1] = ptp_pkg::CAM_ROW1_RST;
		cam_row[2] = ptp_pkg::CAM_ROW2_RST;
		roi_org = ptp_pkg::ROI_ORG_RST;
		roi_sz = ptp_pkg::ROI_SIZE_RST;
		@(posedge arst_n);

		// Directed points under the reset registers.
		p = '{16'sd0, 16'sd0, 16'sd1, 1'b1}; enqueue_point(p);
		p = '{16'sd1919, 16'sd1079, 16'sd1, 1'b1}; enqueue_point(p);
		p = '{16'sd1920, 16'sd5, 16'sd1, 1'b1}; enqueue_point(p);
		p = '{16'sd5, 16'sd1080, 16'sd1, 1'b1}; enqueue_point(p);
		p = '{-16'sd1, 16'sd0, 16'sd1, 1'b1}; enqueue_point(p);
		p = '{16'sd100, 16'sd100, 16'sd0, 1'b1}; enqueue_point(p);
		p = '{16'sd3, 16'sd4, 16'sd7, 1'b0}; enqueue_point(p);
		p = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1}; enqueue_point(p);
		p = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1}; enqueue_point(p);
		p = '{16'sh8000, 16'sh8000, 16'sh8001, 1'b1}; enqueue_point(p);
		p = '{16'sh7FFF, 16'sh0000, 16'sh0001, 1'b1}; enqueue_point(p);
		p = '{-16'sd7, -16'sd9, -16'sd2, 1'b1}; enqueue_point(p);
		p = '{16'shFFFF, 16'shFFFF, 16'shFFFF, 1'b0}; enqueue_point(p);
		p = '{16'sd1000, 16'sd500, 16'sd3, 1'b1}; enqueue_point(p);
		queue_points(300, 1'b1);
		drain();

		// Small region away from the origin; writes to unused indexes.
		write_reg(ptp_pkg::CFG_ROI_ORG, 64'({12'd50, 12'd100}));
		write_reg(ptp_pkg::CFG_ROI_SIZE, 64'hFFFF_FFFF_FF00_0000 | {12'd32, 12'd64});
		write_reg(4'd8, 64'h0123_4567_89AB_CDEF);
		write_reg(4'd15, '1);
		queue_points(250, 1'b1);
		drain();

		// Region that runs past the pixel range and gets clipped.
		write_reg(ptp_pkg::CFG_ROI_ORG, 64'({12'd4000, 12'd4000}));
		write_reg(ptp_pkg::CFG_ROI_SIZE, 64'({12'd4095, 12'd4095}));
		queue_points(200, 1'b1);
		drain();

		// Empty region.
		write_reg(ptp_pkg::CFG_ROI_ORG, 64'({12'd0, 12'd0}));
		write_reg(ptp_pkg::CFG_ROI_SIZE, 64'({12'd0, 12'd0}));
		queue_points(100, 1'b1);
		drain();

		// Random transform and camera over the pixel range but its last column and row.
		write_reg(ptp_pkg::CFG_ROI_SIZE, '1);
		for (int r = 0; r < 6; r++)
			write_reg(ptp_pkg::CFG_IDX_W'(r), {$urandom, $urandom});
		queue_points(300, 1'b0);
		drain();

		// Extreme register values: all ones, then most negative and most positive entries.
		for (int r = 0; r < 6; r++) write_reg(ptp_pkg::CFG_IDX_W'(r), '1);
		queue_points(50, 1'b0);
		drain();
		write_reg(ptp_pkg::CFG_XF_ROW0, 64'h8000_8000_8000_8000);
		write_reg(ptp_pkg::CFG_XF_ROW1, 64'h7FFF_7FFF_7FFF_7FFF);
		write_reg(ptp_pkg::CFG_XF_ROW2, 64'h8000_7FFF_8000_7FFF);
		write_reg(ptp_pkg::CFG_CAM_ROW0, 64'(60'h80000_7FFFF_80000));
		write_reg(ptp_pkg::CFG_CAM_ROW1, 64'(60'h7FFFF_80000_7FFFF));
		write_reg(ptp_pkg::CFG_CAM_ROW2, 64'(60'h00001_00000_00001));
		queue_points(50, 1'b0);
		drain();

		// Back to a plain projection, no idling on either side.
		load_identity();
		write_reg(ptp_pkg::CFG_ROI_ORG, 64'({12'd20, 12'd10}));
		write_reg(ptp_pkg::CFG_ROI_SIZE, 64'({12'd700, 12'd1000}));
		calm = 1'b1;
		queue_points(380, 1'b1);
		while (pending_points.size() > 0 || in_valid || expected_pixels.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		if (errors == 0) begin
			$display("point_to_pixel_projection verification clean");
		end else begin
			$display("point_to_pixel_projection verification failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ptp_pkg.sv
hdl/ptp_xform.sv
hdl/ptp_proj.sv
hdl/ptp_fdiv.sv
hdl/point_to_pixel_projection.sv
sim/point_to_pixel_projection_test.sv
